// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define AST_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("next-cycle implication failed");

`endif

// ===== hdl/cbfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfd_pkg
// Types, constants and the control store of the cubic B-spline point
// generator.
// ----------------------------------------------------------------------------
package cbfd_pkg;

    localparam int COORD_W        = 32;
    localparam int DIFF_W         = 64;
    localparam int XFRAC          = DIFF_W - COORD_W;
    localparam int TEMP_W         = 36;
    localparam int ACC_W          = 72;
    localparam int DIV_CHUNK      = 8;
    localparam int DIV_STEPS      = ACC_W / DIV_CHUNK;
    localparam int DIV_CNT_W      = 4;
    localparam int MAX_STEPS_LOG2 = 6;
    localparam int STEPS_W        = 3;
    localparam int RUN_W          = MAX_STEPS_LOG2 + 1;
    localparam int WINDOW_N       = 4;
    localparam int SEEN_W         = 3;
    localparam int PC_W           = 6;
    localparam int SHAMT_W        = 6;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 3'd4;

    // ceil(m / 3) = floor((m + 2 + 3 * 2^70) / 3) - 2^70
    localparam logic [ACC_W-1:0] DIV_BIAS = (72'd3 << 70) + 72'd2;

    // floor(v / 3) = (v * 683) >> 11 for v below 768
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SH  = 11;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      new_curve;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      last_point;
    } curve_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_LOAD,
        ALU_LOADN,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [2:0] {
        SRC_G0,
        SRC_G1,
        SRC_G2,
        SRC_G3,
        SRC_TA,
        SRC_TB,
        SRC_TC
    } src_t;

    typedef enum logic [1:0] {
        TMP_NONE,
        TMP_TA,
        TMP_TB,
        TMP_TC
    } tmp_wr_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_LOAD,
        DIV_STEP
    } div_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_DIV_MORE,
        JMP_RUN_MORE
    } jmp_t;

    typedef struct packed {
        logic              idle;
        alu_op_t           alu_op;
        src_t              src;
        logic [5:0]        sh_c;
        logic [1:0]        sh_m;
        tmp_wr_t           tmp_wr;
        div_op_t           div_op;
        logic              diff_wr;
        logic [1:0]        diff_idx;
        logic              emit;
        jmp_t              jmp;
        logic [PC_W-1:0]   target;
    } ucw_t;

    typedef struct packed {
        logic               shift_in;
        alu_op_t            alu_op;
        src_t               src;
        logic [SHAMT_W-1:0] shamt;
        tmp_wr_t            tmp_wr;
        div_op_t            div_op;
        logic               diff_wr;
        logic [1:0]         diff_idx;
        logic               emit;
    } lane_ctl_t;

    localparam ucw_t UCW_NOP = '{
        idle:     1'b0,
        alu_op:   ALU_NONE,
        src:      SRC_G0,
        sh_c:     6'd0,
        sh_m:     2'd0,
        tmp_wr:   TMP_NONE,
        div_op:   DIV_NONE,
        diff_wr:  1'b0,
        diff_idx: 2'd0,
        emit:     1'b0,
        jmp:      JMP_NEXT,
        target:   '0
    };

    localparam logic [PC_W-1:0] UA_IDLE   = 6'd0;
    localparam logic [PC_W-1:0] UA_FIRST  = 6'd1;
    localparam logic [PC_W-1:0] UA_DIV_D0 = 6'd21;
    localparam logic [PC_W-1:0] UA_DIV_D3 = 6'd25;
    localparam logic [PC_W-1:0] UA_DIV_D2 = 6'd30;
    localparam logic [PC_W-1:0] UA_DIV_D1 = 6'd35;
    localparam logic [PC_W-1:0] UA_RUN    = 6'd37;

    function automatic ucw_t uc_alu(alu_op_t op, src_t src, logic [5:0] c, logic [1:0] m);
        ucw_t w;
        w        = UCW_NOP;
        w.alu_op = op;
        w.src    = src;
        w.sh_c   = c;
        w.sh_m   = m;
        return w;
    endfunction

    function automatic ucw_t uc_div_load();
        ucw_t w;
        w        = UCW_NOP;
        w.div_op = DIV_LOAD;
        return w;
    endfunction

    function automatic ucw_t uc_div_step(logic [PC_W-1:0] self);
        ucw_t w;
        w        = UCW_NOP;
        w.div_op = DIV_STEP;
        w.jmp    = JMP_DIV_MORE;
        w.target = self;
        return w;
    endfunction

    // control store: a, b, c into temps, then the four difference terms,
    // each divided by three and stored, then the emit loop
    function automatic ucw_t ucode(logic [PC_W-1:0] pc);
        ucw_t w;
        w = UCW_NOP;
        unique case (pc)
            6'd0:
            begin
                w.idle = 1'b1;
            end
            6'd1:  w = uc_alu(ALU_LOADN, SRC_G0, 6'd0, 2'd0);
            6'd2:  w = uc_alu(ALU_ADD,   SRC_G1, 6'd1, 2'd0);
            6'd3:  w = uc_alu(ALU_ADD,   SRC_G1, 6'd0, 2'd0);
            6'd4:  w = uc_alu(ALU_SUB,   SRC_G2, 6'd1, 2'd0);
            6'd5:  w = uc_alu(ALU_SUB,   SRC_G2, 6'd0, 2'd0);
            6'd6:
            begin
                w        = uc_alu(ALU_ADD, SRC_G3, 6'd0, 2'd0);
                w.tmp_wr = TMP_TA;
            end
            6'd7:  w = uc_alu(ALU_LOAD,  SRC_G0, 6'd1, 2'd0);
            6'd8:  w = uc_alu(ALU_ADD,   SRC_G0, 6'd0, 2'd0);
            6'd9:  w = uc_alu(ALU_SUB,   SRC_G1, 6'd2, 2'd0);
            6'd10: w = uc_alu(ALU_SUB,   SRC_G1, 6'd1, 2'd0);
            6'd11: w = uc_alu(ALU_ADD,   SRC_G2, 6'd1, 2'd0);
            6'd12:
            begin
                w        = uc_alu(ALU_ADD, SRC_G2, 6'd0, 2'd0);
                w.tmp_wr = TMP_TB;
            end
            6'd13: w = uc_alu(ALU_LOADN, SRC_G0, 6'd1, 2'd0);
            6'd14: w = uc_alu(ALU_SUB,   SRC_G0, 6'd0, 2'd0);
            6'd15: w = uc_alu(ALU_ADD,   SRC_G2, 6'd1, 2'd0);
            6'd16:
            begin
                w        = uc_alu(ALU_ADD, SRC_G2, 6'd0, 2'd0);
                w.tmp_wr = TMP_TC;
            end
            6'd17: w = uc_alu(ALU_LOAD,  SRC_G0, 6'd31, 2'd0);
            6'd18: w = uc_alu(ALU_ADD,   SRC_G1, 6'd33, 2'd0);
            6'd19: w = uc_alu(ALU_ADD,   SRC_G2, 6'd31, 2'd0);
            6'd20: w = uc_div_load();
            6'd21: w = uc_div_step(UA_DIV_D0);
            6'd22:
            begin
                w          = uc_alu(ALU_LOAD, SRC_TA, 6'd33, 2'd3);
                w.diff_wr  = 1'b1;
                w.diff_idx = 2'd0;
            end
            6'd23: w = uc_alu(ALU_ADD,   SRC_TA, 6'd32, 2'd3);
            6'd24: w = uc_div_load();
            6'd25: w = uc_div_step(UA_DIV_D3);
            6'd26:
            begin
                w          = uc_alu(ALU_LOAD, SRC_TA, 6'd33, 2'd3);
                w.diff_wr  = 1'b1;
                w.diff_idx = 2'd3;
            end
            6'd27: w = uc_alu(ALU_ADD,   SRC_TA, 6'd32, 2'd3);
            6'd28: w = uc_alu(ALU_ADD,   SRC_TB, 6'd32, 2'd2);
            6'd29: w = uc_div_load();
            6'd30: w = uc_div_step(UA_DIV_D2);
            6'd31:
            begin
                w          = uc_alu(ALU_LOAD, SRC_TA, 6'd31, 2'd3);
                w.diff_wr  = 1'b1;
                w.diff_idx = 2'd2;
            end
            6'd32: w = uc_alu(ALU_ADD,   SRC_TB, 6'd31, 2'd2);
            6'd33: w = uc_alu(ALU_ADD,   SRC_TC, 6'd31, 2'd1);
            6'd34: w = uc_div_load();
            6'd35: w = uc_div_step(UA_DIV_D1);
            6'd36:
            begin
                w.diff_wr  = 1'b1;
                w.diff_idx = 2'd1;
            end
            6'd37:
            begin
                w.emit   = 1'b1;
                w.jmp    = JMP_RUN_MORE;
                w.target = UA_RUN;
            end
            6'd38:
            begin
                w.jmp    = JMP_ALWAYS;
                w.target = UA_IDLE;
            end
            default:
            begin
                w.jmp    = JMP_ALWAYS;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/cbfd_lane.sv =====
// ----------------------------------------------------------------------------
// cbfd_lane
// One coordinate datapath: control point window, accumulator with shifted
// operand, byte-serial ceiling divide by three, and the forward difference
// registers that produce the curve coordinate.
// ----------------------------------------------------------------------------
module cbfd_lane (
    input  logic                                 clk,
    input  logic signed [cbfd_pkg::COORD_W-1:0]  coord,
    input  cbfd_pkg::lane_ctl_t                  ctl,
    output logic signed [cbfd_pkg::COORD_W-1:0]  result
);

    logic signed [cbfd_pkg::COORD_W-1:0] win_reg  [cbfd_pkg::WINDOW_N];
    logic signed [cbfd_pkg::COORD_W-1:0] win_next [cbfd_pkg::WINDOW_N];
    logic [cbfd_pkg::TEMP_W-1:0]         ta_reg, ta_next;
    logic [cbfd_pkg::TEMP_W-1:0]         tb_reg, tb_next;
    logic [cbfd_pkg::TEMP_W-1:0]         tc_reg, tc_next;
    logic [cbfd_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic [cbfd_pkg::ACC_W-1:0]          u_reg, u_next;
    logic [1:0]                          rem_reg, rem_next;
    logic [cbfd_pkg::DIFF_W-1:0]         quo_reg, quo_next;
    logic [cbfd_pkg::DIFF_W-1:0]         diff_reg  [4];
    logic [cbfd_pkg::DIFF_W-1:0]         diff_next [4];
    logic signed [cbfd_pkg::COORD_W-1:0] res_reg, res_next;

    logic [cbfd_pkg::TEMP_W-1:0] opnd;
    logic [cbfd_pkg::ACC_W-1:0]  opnd_ext;
    logic [cbfd_pkg::ACC_W-1:0]  opnd_sh;
    logic [9:0]                  div_v;
    logic [19:0]                 div_prod;
    logic [7:0]                  div_q;
    logic [9:0]                  div_q3;
    logic [9:0]                  div_r;
    logic [cbfd_pkg::DIFF_W-1:0] pos_next;

    always_comb
    begin
        unique case (ctl.src)
            cbfd_pkg::SRC_G0: opnd = cbfd_pkg::TEMP_W'(win_reg[0]);
            cbfd_pkg::SRC_G1: opnd = cbfd_pkg::TEMP_W'(win_reg[1]);
            cbfd_pkg::SRC_G2: opnd = cbfd_pkg::TEMP_W'(win_reg[2]);
            cbfd_pkg::SRC_G3: opnd = cbfd_pkg::TEMP_W'(win_reg[3]);
            cbfd_pkg::SRC_TA: opnd = ta_reg;
            cbfd_pkg::SRC_TB: opnd = tb_reg;
            cbfd_pkg::SRC_TC: opnd = tc_reg;
            default:          opnd = '0;
        endcase
        opnd_ext = {{(cbfd_pkg::ACC_W - cbfd_pkg::TEMP_W){opnd[cbfd_pkg::TEMP_W-1]}}, opnd};
        opnd_sh  = opnd_ext << ctl.shamt;

        unique case (ctl.alu_op)
            cbfd_pkg::ALU_NONE:  acc_next = acc_reg;
            cbfd_pkg::ALU_LOAD:  acc_next = opnd_sh;
            cbfd_pkg::ALU_LOADN: acc_next = -opnd_sh;
            cbfd_pkg::ALU_ADD:   acc_next = acc_reg + opnd_sh;
            cbfd_pkg::ALU_SUB:   acc_next = acc_reg - opnd_sh;
            default:             acc_next = acc_reg;
        endcase

        ta_next = ta_reg;
        tb_next = tb_reg;
        tc_next = tc_reg;
        unique case (ctl.tmp_wr)
            cbfd_pkg::TMP_NONE: ;
            cbfd_pkg::TMP_TA:   ta_next = acc_next[cbfd_pkg::TEMP_W-1:0];
            cbfd_pkg::TMP_TB:   tb_next = acc_next[cbfd_pkg::TEMP_W-1:0];
            cbfd_pkg::TMP_TC:   tc_next = acc_next[cbfd_pkg::TEMP_W-1:0];
            default:            ;
        endcase

        win_next = win_reg;
        if (ctl.shift_in)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = coord;
        end

        div_v    = {rem_reg, u_reg[cbfd_pkg::ACC_W-1 -: cbfd_pkg::DIV_CHUNK]};
        div_prod = 20'(div_v) * 20'(cbfd_pkg::RECIP3);
        div_q    = div_prod[cbfd_pkg::RECIP3_SH +: 8];
        div_q3   = {1'b0, div_q, 1'b0} + {2'b00, div_q};
        div_r    = div_v - div_q3;

        u_next   = u_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        unique case (ctl.div_op)
            cbfd_pkg::DIV_NONE: ;
            cbfd_pkg::DIV_LOAD:
            begin
                u_next   = acc_reg + cbfd_pkg::DIV_BIAS;
                rem_next = 2'd0;
            end
            cbfd_pkg::DIV_STEP:
            begin
                u_next   = u_reg << cbfd_pkg::DIV_CHUNK;
                rem_next = div_r[1:0];
                quo_next = {quo_reg[cbfd_pkg::DIFF_W-cbfd_pkg::DIV_CHUNK-1:0], div_q};
            end
            default: ;
        endcase

        diff_next = diff_reg;
        pos_next  = diff_reg[0] + diff_reg[1];
        res_next  = res_reg;
        if (ctl.diff_wr)
        begin
            diff_next[ctl.diff_idx] = quo_reg;
        end
        else if (ctl.emit)
        begin
            diff_next[0] = pos_next;
            diff_next[1] = diff_reg[1] + diff_reg[2];
            diff_next[2] = diff_reg[2] + diff_reg[3];
            res_next     = pos_next[cbfd_pkg::DIFF_W-1 -: cbfd_pkg::COORD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        tc_reg   <= tc_next;
        acc_reg  <= acc_next;
        u_reg    <= u_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;

endmodule

// ===== hdl/cbfd_seq.sv =====
// ----------------------------------------------------------------------------
// cbfd_seq
// Microcode sequencer: step counter, control store decode, conditional
// jumps, window fill count, step register and output handshake.
// ----------------------------------------------------------------------------
module cbfd_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            point_valid,
    input  logic                            new_curve,
    input  logic                            cfg_wen,
    input  logic [cbfd_pkg::STEPS_W-1:0]    cfg_wdata,
    input  logic                            curve_stall,
    output logic                            point_stall,
    output logic                            curve_valid,
    output logic                            last_point,
    output cbfd_pkg::lane_ctl_t             ctl
);

    logic [cbfd_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic [cbfd_pkg::SEEN_W-1:0]    seen_reg, seen_next;
    logic [cbfd_pkg::STEPS_W-1:0]   steps_reg, steps_next;
    logic [cbfd_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [cbfd_pkg::RUN_W-1:0]     run_cnt_reg, run_cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           last_reg, last_next;

    cbfd_pkg::ucw_t                 w;
    logic                           in_xfer;
    logic                           out_xfer;
    logic                           can_emit;
    logic                           emit_go;
    logic                           start;
    logic [cbfd_pkg::SEEN_W-1:0]    seen_base;
    logic [cbfd_pkg::STEPS_W-1:0]   s_eff;
    logic [cbfd_pkg::RUN_W-1:0]     run_n;
    logic [cbfd_pkg::RUN_W-1:0]     run_inc;
    logic                           run_last;
    logic [cbfd_pkg::PC_W:0]        shamt_full;
    logic [cbfd_pkg::PC_W-1:0]      pc_inc;

    always_comb
    begin
        w        = cbfd_pkg::ucode(pc_reg);
        in_xfer  = point_valid && w.idle;
        out_xfer = out_valid_reg && !curve_stall;
        can_emit = !out_valid_reg || !curve_stall;
        emit_go  = w.emit && can_emit;

        seen_base = new_curve ? '0 : seen_reg;
        seen_next = seen_reg;
        if (in_xfer)
        begin
            seen_next = (seen_base < cbfd_pkg::SEEN_W'(cbfd_pkg::WINDOW_N))
                        ? cbfd_pkg::SEEN_W'(seen_base + 1'b1) : seen_base;
        end
        start = in_xfer && (seen_next == cbfd_pkg::SEEN_W'(cbfd_pkg::WINDOW_N));

        steps_next = cfg_wen ? cfg_wdata : steps_reg;
        s_eff      = (steps_reg > cbfd_pkg::STEPS_W'(cbfd_pkg::MAX_STEPS_LOG2))
                     ? cbfd_pkg::STEPS_W'(cbfd_pkg::MAX_STEPS_LOG2) : steps_reg;
        run_n      = cbfd_pkg::RUN_W'(1) << s_eff;
        run_inc    = cbfd_pkg::RUN_W'(run_cnt_reg + 1'b1);
        run_last   = (run_inc == run_n);

        shamt_full = {1'b0, w.sh_c}
                     - (cbfd_pkg::PC_W'(w.sh_m) * cbfd_pkg::PC_W'(s_eff));

        run_cnt_next = run_cnt_reg;
        if (start)
        begin
            run_cnt_next = '0;
        end
        else if (emit_go)
        begin
            run_cnt_next = run_inc;
        end

        div_cnt_next = div_cnt_reg;
        unique case (w.div_op)
            cbfd_pkg::DIV_NONE: ;
            cbfd_pkg::DIV_LOAD: div_cnt_next = cbfd_pkg::DIV_CNT_W'(cbfd_pkg::DIV_STEPS);
            cbfd_pkg::DIV_STEP: div_cnt_next = div_cnt_reg - 1'b1;
            default: ;
        endcase

        pc_inc  = pc_reg + 1'b1;
        pc_next = pc_reg;
        if (w.idle)
        begin
            pc_next = start ? cbfd_pkg::UA_FIRST : pc_reg;
        end
        else if (!(w.emit && !can_emit))
        begin
            unique case (w.jmp)
                cbfd_pkg::JMP_NEXT:     pc_next = pc_inc;
                cbfd_pkg::JMP_ALWAYS:   pc_next = w.target;
                cbfd_pkg::JMP_DIV_MORE:
                    pc_next = (div_cnt_reg != cbfd_pkg::DIV_CNT_W'(1)) ? w.target : pc_inc;
                cbfd_pkg::JMP_RUN_MORE: pc_next = run_last ? pc_inc : w.target;
                default:                pc_next = cbfd_pkg::UA_IDLE;
            endcase
        end

        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        if (emit_go)
        begin
            out_valid_next = 1'b1;
            last_next      = run_last;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        ctl.shift_in = in_xfer;
        ctl.alu_op   = w.alu_op;
        ctl.src      = w.src;
        ctl.shamt    = shamt_full[cbfd_pkg::SHAMT_W-1:0];
        ctl.tmp_wr   = w.tmp_wr;
        ctl.div_op   = w.div_op;
        ctl.diff_wr  = w.diff_wr;
        ctl.diff_idx = w.diff_idx;
        ctl.emit     = emit_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= cbfd_pkg::UA_IDLE;
            seen_reg      <= '0;
            steps_reg     <= cbfd_pkg::STEPS_RESET;
            div_cnt_reg   <= '0;
            run_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            seen_reg      <= seen_next;
            steps_reg     <= steps_next;
            div_cnt_reg   <= div_cnt_next;
            run_cnt_reg   <= run_cnt_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    assign point_stall = !w.idle;
    assign curve_valid = out_valid_reg;
    assign last_point  = last_reg;

endmodule

// ===== hdl/cubic_bspline_fwd_diff_points.sv =====
// ----------------------------------------------------------------------------
// cubic_bspline_fwd_diff_points
// Uniform cubic B-spline point generator with forward differences. Control
// points (signed Q16.16) enter one per transfer and the last four form the
// window; new_curve restarts the count. From the fourth point of a curve on,
// each point yields one segment of 2^steps_log2 curve points (steps_log2
// above 6 acts as 6), t = delta to t = 1, the last one flagged. A point that
// does not complete a window is taken without a stall. A segment point stalls
// the input until its segment is out: the microcode forms the basis terms,
// runs four byte-serial divide-by-three passes with load and store steps
// and emits the points one by one, and a stall on the result side holds
// the emit loop. The last result sits in an output register while the next
// point is taken. The user must write steps_log2 only while the block is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cubic_bspline_fwd_diff_points (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             point_valid,
    output logic                             point_stall,
    input  cbfd_pkg::point_t                 point,
    output logic                             curve_valid,
    input  logic                             curve_stall,
    output cbfd_pkg::curve_t                 curve,
    input  logic                             cfg_wen,
    input  logic [cbfd_pkg::STEPS_W-1:0]     cfg_wdata
);

    cbfd_pkg::lane_ctl_t                 ctl;
    logic                                last_point;
    logic signed [cbfd_pkg::COORD_W-1:0] x_res;
    logic signed [cbfd_pkg::COORD_W-1:0] y_res;

    cbfd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .new_curve   (point.new_curve),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .curve_stall (curve_stall),
        .point_stall (point_stall),
        .curve_valid (curve_valid),
        .last_point  (last_point),
        .ctl         (ctl)
    );

    cbfd_lane u_lane_x (
        .clk    (clk),
        .coord  (point.point_x),
        .ctl    (ctl),
        .result (x_res)
    );

    cbfd_lane u_lane_y (
        .clk    (clk),
        .coord  (point.point_y),
        .ctl    (ctl),
        .result (y_res)
    );

    assign curve.out_x      = x_res;
    assign curve.out_y      = y_res;
    assign curve.last_point = last_point;

endmodule

// ===== hdl/cbfd_checker.sv =====
// ----------------------------------------------------------------------------
// cbfd_checker
// Port-level checks of the curve point generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbfd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              point_valid,
    input logic              point_stall,
    input logic              curve_valid,
    input logic              curve_stall,
    input cbfd_pkg::curve_t  curve
);

    `AST_NEXT(a_curve_hold, clk, rst_n, curve_valid && curve_stall, curve_valid && $stable(curve))
    `AST_IMP(a_run_blocks_input, clk, rst_n, curve_valid && !curve.last_point, point_stall)
    `AST_NEXT(a_mid_run_stall, clk, rst_n, curve_valid && !curve_stall && !curve.last_point, point_stall)
    `AST_NEXT(a_no_result_on_take, clk, rst_n, point_valid && !point_stall && !curve_valid, !curve_valid)

endmodule

bind cubic_bspline_fwd_diff_points cbfd_checker u_cbfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .curve       (curve)
);

// ===== verif/cbfd_curve_checker.sv =====
// ----------------------------------------------------------------------------
// cbfd_curve_checker
// Watches the point, curve and config ports of the B-spline point generator.
// Each accepted control point updates a shadow window; once a curve has four
// points, the segment's forward differences are set up from the basis and
// stepped out into a queue of owed curve points. Each curve transfer is
// compared field by field with the oldest owed point. The error count and
// the number of owed points go back to the test top.
// ----------------------------------------------------------------------------
module cbfd_curve_checker
    import cbfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    input  logic               point_stall,
    input  point_t             point,
    input  logic               curve_valid,
    input  logic               curve_stall,
    input  curve_t             curve,
    input  logic               cfg_wen,
    input  logic [STEPS_W-1:0] cfg_wdata,
    output int                 fail_count,
    output int                 points_owed
);

    typedef logic [WINDOW_N-1:0][DIFF_W-1:0] diff_set_t;

    logic [STEPS_W-1:0]        steps_log2 = STEPS_RESET;
    logic signed [COORD_W-1:0] win_x [WINDOW_N];
    logic signed [COORD_W-1:0] win_y [WINDOW_N];
    int                        seen   = 0;
    int                        errors = 0;
    curve_t                    owed_q [$];

    // ceil(p * 2^XFRAC / (6 * 2^k)), kept modulo 2^DIFF_W
    function automatic logic [DIFF_W-1:0] ceil_to_grid(logic signed [127:0] p, int k);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] q;
        num = p <<< XFRAC;
        den = 128'sd6 <<< k;
        if (num >= 0)
            q = (num + den - 1) / den;
        else
            q = num / den;
        return q[DIFF_W-1:0];
    endfunction

    function automatic diff_set_t start_diffs(logic signed [COORD_W-1:0] c0,
                                              logic signed [COORD_W-1:0] c1,
                                              logic signed [COORD_W-1:0] c2,
                                              logic signed [COORD_W-1:0] c3,
                                              int s);
        logic signed [127:0] g0;
        logic signed [127:0] g1;
        logic signed [127:0] g2;
        logic signed [127:0] g3;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] d;
        logic signed [127:0] p1;
        logic signed [127:0] p2;
        diff_set_t           r;
        g0 = c0;
        g1 = c1;
        g2 = c2;
        g3 = c3;
        a  = -g0 + 3 * g1 - 3 * g2 + g3;
        b  = 3 * g0 - 6 * g1 + 3 * g2;
        c  = -3 * g0 + 3 * g2;
        d  = g0 + 4 * g1 + g2;
        p1 = 128'sd1 <<< s;
        p2 = 128'sd1 <<< (2 * s);
        r[0] = ceil_to_grid(d, 0);
        r[1] = ceil_to_grid(a + b * p1 + c * p2, 3 * s);
        r[2] = ceil_to_grid(6 * a + 2 * b * p1, 3 * s);
        r[3] = ceil_to_grid(6 * a, 3 * s);
        return r;
    endfunction

    task automatic predict_segment(point_t p);
        int        s;
        int        n;
        diff_set_t dx;
        diff_set_t dy;
        curve_t    nxt;
        if (p.new_curve)
            seen = 0;
        for (int i = 0; i < WINDOW_N - 1; i++)
        begin
            win_x[i] = win_x[i + 1];
            win_y[i] = win_y[i + 1];
        end
        win_x[WINDOW_N - 1] = p.point_x;
        win_y[WINDOW_N - 1] = p.point_y;
        if (seen < WINDOW_N)
            seen++;
        if (seen < WINDOW_N)
            return;
        s  = (steps_log2 > MAX_STEPS_LOG2) ? MAX_STEPS_LOG2 : int'(steps_log2);
        n  = 1 << s;
        dx = start_diffs(win_x[0], win_x[1], win_x[2], win_x[3], s);
        dy = start_diffs(win_y[0], win_y[1], win_y[2], win_y[3], s);
        for (int i = 0; i < n; i++)
        begin
            dx[0] = dx[0] + dx[1];
            dx[1] = dx[1] + dx[2];
            dx[2] = dx[2] + dx[3];
            dy[0] = dy[0] + dy[1];
            dy[1] = dy[1] + dy[2];
            dy[2] = dy[2] + dy[3];
            nxt.out_x      = dx[0][DIFF_W-1:XFRAC];
            nxt.out_y      = dy[0][DIFF_W-1:XFRAC];
            nxt.last_point = (i == n - 1);
            owed_q = {owed_q, nxt};
        end
    endtask

    task automatic check_curve(curve_t got);
        curve_t want;
        if (owed_q.size() == 0)
        begin
            $error("curve transfer with nothing owed: out_x %0d out_y %0d last_point %0d",
                   got.out_x, got.out_y, got.last_point);
            errors++;
            return;
        end
        want = owed_q.pop_front();
        if (got.out_x !== want.out_x)
        begin
            $error("out_x mismatch: expected %0d, got %0d", want.out_x, got.out_x);
            errors++;
        end
        if (got.out_y !== want.out_y)
        begin
            $error("out_y mismatch: expected %0d, got %0d", want.out_y, got.out_y);
            errors++;
        end
        if (got.last_point !== want.last_point)
        begin
            $error("last_point mismatch: expected %0d, got %0d",
                   want.last_point, got.last_point);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            steps_log2 = STEPS_RESET;
            for (int i = 0; i < WINDOW_N; i++)
            begin
                win_x[i] = '0;
                win_y[i] = '0;
            end
            seen = 0;
            owed_q.delete();
        end
        else
        begin
            if (curve_valid && !curve_stall)
                check_curve(curve);
            if (point_valid && !point_stall)
                predict_segment(point);
            if (cfg_wen)
                steps_log2 = cfg_wdata;
        end
        fail_count  <= errors;
        points_owed <= owed_q.size();
    end

endmodule

// ===== verif/cubic_bspline_fwd_diff_points_test.sv =====
// ----------------------------------------------------------------------------
// cubic_bspline_fwd_diff_points_test
// Drives control points into the B-spline point generator: a directed run
// over coordinate extremes, curve restarts, short curves and the step count
// limits, then random curves over a range of step counts with random gaps on
// both sides. A side checker predicts and compares every curve point.
// ----------------------------------------------------------------------------
module cubic_bspline_fwd_diff_points_test;

    import cbfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int DRAIN_CYCLES   = 12;
    localparam int IDLE_PCT       = 11;
    localparam int PHASE_POINTS   = 46;
    localparam int PHASES         = 8;
    localparam int CALM_PHASE     = 3;
    localparam int PAUSE_PHASE    = 2;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFFFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
    localparam logic signed [COORD_W-1:0] C_ONE = 32'sh00010000;

    localparam logic [PHASES-1:0][STEPS_W-1:0] STEPS_PLAN =
        {3'd7, 3'd4, 3'd0, 3'd5, 3'd3, 3'd2, 3'd6, 3'd1};

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               point_valid = 1'b0;
    logic               point_stall;
    point_t             point       = '0;
    logic               curve_valid;
    logic               curve_stall = 1'b0;
    curve_t             curve;
    logic               cfg_wen     = 1'b0;
    logic [STEPS_W-1:0] cfg_wdata   = '0;
    logic               calm        = 1'b0;
    int                 fail_count;
    int                 points_owed;
    int                 quiet_cycles = 0;

    cubic_bspline_fwd_diff_points dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve       (curve),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata)
    );

    cbfd_curve_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve       (curve),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .points_owed (points_owed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        curve_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if ((point_valid && !point_stall) || (curve_valid && !curve_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = C_MAX;
            1:       v = C_MIN;
            2:       v = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic send_point(logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y,
                              logic nc);
        while (take_break())
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid     <= 1'b1;
        point.point_x   <= x;
        point.point_y   <= y;
        point.new_curve <= nc;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        point_valid <= 1'b0;
        do
            @(posedge clk);
        while (points_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_steps(logic [STEPS_W-1:0] v);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic send_curve(int len);
        for (int j = 0; j < len; j++)
            send_point(pick_coord(), pick_coord(), j == 0);
    endtask

    initial
    begin
        int  sent;
        int  kind;
        int  len;
        bit  paused;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default step count, extremes, restarts and short curves
        send_point(C_MAX, C_MAX, 1'b1);
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(32'sd0, 32'sd0, 1'b0);
        send_point(-32'sd1, -32'sd1, 1'b0);
        send_point(32'sd1, -32'sd1, 1'b1);
        send_point(32'sd2, 32'sd3, 1'b0);
        send_point(C_ONE, -C_ONE, 1'b1);
        send_point(-C_ONE, C_ONE, 1'b0);
        send_point(C_MAX, 32'sd0, 1'b0);
        send_point(C_MIN, C_ONE, 1'b0);

        // step count above the limit
        write_steps(3'd7);
        send_point(C_MIN, C_MAX, 1'b1);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0);
        send_point(C_ONE, C_ONE, 1'b1);

        // one point per segment
        write_steps(3'd0);
        send_point(C_MAX, C_MAX, 1'b1);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_steps(STEPS_PLAN[ph]);
            calm   <= (ph == CALM_PHASE);
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_POINTS)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    send_point(pick_coord(), pick_coord(), $urandom_range(0, 1));
                    sent++;
                end
                else
                begin
                    len = (kind == 1) ? $urandom_range(1, 3) : $urandom_range(4, 10);
                    send_curve(len);
                    sent += len;
                end
                if (ph == PAUSE_PHASE && !paused && sent >= PHASE_POINTS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        point_valid <= 1'b0;
        do
            @(posedge clk);
        while (points_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && points_owed == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
